// ===== hw/rtl/mse_pkg.sv =====
// Shared types, constants and cipher/CRC functions for the multiboot stream encryptor.
package mse_pkg;

   localparam logic [31:0] SEDO_WORD   = 32'h6f64_6573;
   localparam logic [31:0] KAWA_WORD   = 32'h6177_614b;
   localparam logic [31:0] BY_WORD     = 32'h2079_6220;
   localparam logic [15:0] CRC_TAPS    = 16'ha1c1;
   localparam logic [15:0] CRC_INIT    = 16'h15a0;
   localparam logic [17:0] HEADER_END  = 18'h000C0;
   localparam logic [17:0] OFFSET_STEP = 18'd4;
   localparam logic [31:0] OFFSET_BIAS = 32'h0200_0000;

   // Two key steps folded into one: k*K*K + (K + 1)
   localparam logic [31:0] KAWA_SQ   = 32'(64'(KAWA_WORD) * 64'(KAWA_WORD));
   localparam logic [31:0] KAWA_INC2 = KAWA_WORD + 32'd1;

   localparam logic       CSR_SEED   = 1'b0;
   localparam logic       CSR_LENGTH = 1'b1;

   localparam logic [1:0] KIND_HOST  = 2'd0;
   localparam logic [1:0] KIND_PLAIN = 2'd1;
   localparam logic [1:0] KIND_BODY  = 2'd2;
   localparam logic [1:0] KIND_TRAIL = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One queue entry holds every result of one request.
   typedef struct packed {
      logic [31:0] word0;
      logic [1:0]  kind0;
      logic        two;
      logic [31:0] word1;
      logic [1:0]  kind1;
   } qentry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Bit-serial CRC, used only to build the parallel tables below.
   function automatic logic [15:0] crc_serial(input logic [15:0] c, input logic [31:0] d);
      logic [15:0] r;
      logic [31:0] v;
      r = c;
      v = d;
      for (int k = 0; k < 32; k++) begin
         if (r[0] ^ v[0]) r = (r >> 1) ^ CRC_TAPS;
         else r = r >> 1;
         v = v >> 1;
      end
      return r;
   endfunction

   function automatic logic [15:0][15:0] crc_cols_c();
      logic [15:0][15:0] cols;
      for (int j = 0; j < 16; j++) cols[j] = crc_serial(16'd1 << j, 32'd0);
      return cols;
   endfunction

   function automatic logic [31:0][15:0] crc_cols_d();
      logic [31:0][15:0] cols;
      for (int j = 0; j < 32; j++) cols[j] = crc_serial(16'd0, 32'd1 << j);
      return cols;
   endfunction

   localparam logic [15:0][15:0] CRC_COL_C = crc_cols_c();
   localparam logic [31:0][15:0] CRC_COL_D = crc_cols_d();

   // Parallel CRC over one word: XOR of the columns of every set bit.
   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [31:0] d);
      logic [15:0] r;
      r = '0;
      for (int j = 0; j < 16; j++) if (c[j]) r = r ^ CRC_COL_C[j];
      for (int j = 0; j < 32; j++) if (d[j]) r = r ^ CRC_COL_D[j];
      return r;
   endfunction

   function automatic logic [31:0] host_key(input logic [17:0] len);
      logic [31:0] size;
      logic [31:0] a;
      logic [31:0] b;
      size = ({14'd0, len} - 32'h200) >> 3;
      a = ((size & 32'h3F80) << 1) | ((size & 32'h4000) << 2) | (size & 32'h7F)
          | 32'h0038_0000;
      b = (a >> 8) + (a >> 16) + a;
      b = (b << 24) | a | 32'h8080_8080;
      return b[9] ? (b ^ SEDO_WORD) : (b ^ KAWA_WORD);
   endfunction

   function automatic logic [31:0] mask_term(input logic [17:0] off);
      return 32'd0 - ({14'd0, off} + OFFSET_BIAS);
   endfunction

endpackage

// ===== hw/rtl/mse_front.sv =====
// Front end: takes requests and config writes, runs key/CRC/offset state, builds queue entries.
module mse_front import mse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   input  logic        take,
   input  logic [31:0] plain_word,
   input  logic        first_word,
   input  logic        last_word,
   output qentry_type  entry
);

   logic [31:0] seed_ff, seed_in;
   logic [17:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] crc_ff, crc_in;
   logic [17:0] off_ff, off_in;

   logic [31:0] step1, step2, key1, key2;
   logic [15:0] crc1;
   logic [17:0] off_cur, off_nxt;
   logic        body;
   logic [31:0] enc_word, trail_word;

   always_comb begin
      // Both products come straight from the stored key, side by side.
      step1 = 32'(key_ff * KAWA_WORD) + 32'd1;
      step2 = 32'(key_ff * KAWA_SQ) + KAWA_INC2;
      off_cur = first_word ? 18'd0 : off_ff;
      off_nxt = off_cur + OFFSET_STEP;
      body = (off_cur >= HEADER_END);
      key1 = body ? step1 : key_ff;
      key2 = body ? step2 : step1;
      crc1 = body ? crc_next(crc_ff, plain_word) : crc_ff;
      enc_word = plain_word ^ key1 ^ mask_term(off_cur) ^ BY_WORD;
      trail_word = {len_ff[15:0], crc1} ^ key2 ^ mask_term(off_nxt) ^ BY_WORD;

      if (first_word) begin
         entry.word0 = host_key(len_ff);
         entry.kind0 = KIND_HOST;
         entry.two   = 1'b1;
         entry.word1 = plain_word;
         entry.kind1 = KIND_PLAIN;
      end else begin
         entry.word0 = body ? enc_word : plain_word;
         entry.kind0 = body ? KIND_BODY : KIND_PLAIN;
         entry.two   = last_word;
         entry.word1 = trail_word;
         entry.kind1 = KIND_TRAIL;
      end
   end

   always_comb begin
      seed_in = seed_ff;
      len_in  = len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SEED:   seed_in = csr_data;
            CSR_LENGTH: len_in = csr_data[17:0];
            default:    seed_in = seed_ff;
         endcase
      end
      key_in = key_ff;
      crc_in = crc_ff;
      off_in = off_ff;
      if (take) begin
         off_in = off_nxt;
         if (first_word) begin
            key_in = seed_ff ^ SEDO_WORD;
            crc_in = CRC_INIT;
         end else begin
            key_in = last_word ? key2 : key1;
            crc_in = crc1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         len_ff  <= 18'd192;
         key_ff  <= '0;
         crc_ff  <= CRC_INIT;
         off_ff  <= '0;
      end else begin
         seed_ff <= seed_in;
         len_ff  <= len_in;
         key_ff  <= key_in;
         crc_ff  <= crc_in;
         off_ff  <= off_in;
      end
   end

endmodule

// ===== hw/rtl/mse_queue.sv =====
// Short FIFO of per-request entries between the front and back ends.
module mse_queue import mse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   input  logic       pop,
   output qentry_type head,
   output qstat_type  stat
);

   qentry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      stat.empty = (cnt_ff == '0);
      stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      head = slot_ff[rd_ff];
      wr_in = push ? QPTR_W'((32'(wr_ff) + 1) % QUEUE_DEPTH) : wr_ff;
      rd_in = pop ? QPTR_W'((32'(rd_ff) + 1) % QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/mse_back.sv =====
// Back end: unpacks entries to one result per ready cycle behind an output register.
module mse_back import mse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qentry_type  head,
   input  qstat_type   stat,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;
   logic        pend_ff, pend_in;
   logic [31:0] pword_ff, pword_in;
   logic [1:0]  pkind_ff, pkind_in;
   logic        free;

   always_comb begin
      free = !valid_ff || rsp_tready;
      pop = free && !pend_ff && !stat.empty;
      valid_in = valid_ff;
      word_in  = word_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      pend_in  = pend_ff;
      pword_in = pword_ff;
      pkind_in = pkind_ff;
      if (free) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            word_in  = pword_ff;
            kind_in  = pkind_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (!stat.empty) begin
            valid_in = 1'b1;
            word_in  = head.word0;
            kind_in  = head.kind0;
            last_in  = !head.two;
            pend_in  = head.two;
            pword_in = head.word1;
            pkind_in = head.kind1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
      pword_ff <= pword_in;
      pkind_ff <= pkind_in;
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/multiboot_stream_encryptor.sv =====
// Top level of the multiboot stream encryptor: front end, queue and back end.
//
// Encrypts an image stream word by word with the multiboot stream cipher and appends
// a CRC-16 trailer. A request whose tuser bit is set starts an upload: it first yields
// the host key word (from rom_length), then the word itself, and restarts key, CRC and
// offset. Words in the first 0xC0 bytes pass in the clear; later ones are encrypted. A
// request with tlast set (and not starting an upload) yields its word plus the encrypted
// trailer. Rate: the front end takes one request per clock while the queue has room,
// doing the key multiply and the parallel CRC combinationally; the back end sends one
// result per clock while rsp_tready is high, so a request with two results (upload
// start or final word) sends them in turn. A four-entry queue decouples the two sides,
// and the output register lets a new request in while a result waits. Write csr_index 0
// (session_seed) or 1 (rom_length) only while the block is idle; csr_ready is always high.
module multiboot_stream_encryptor import mse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // plain_word
   input  logic        req_tuser,   // first_word
   input  logic        req_tlast,   // last_word
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // wire_word
   output logic [1:0]  rsp_tuser,   // word_kind
   output logic        rsp_tlast,   // end_of_run
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   qentry_type entry;
   qentry_type head;
   qstat_type  stat;
   logic       take;
   logic       pop;

   // Accept while the queue has room; the back end drains it on its own.
   assign req_tready = !stat.full;
   assign take       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   mse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .take       (take),
      .plain_word (req_tdata),
      .first_word (req_tuser),
      .last_word  (req_tlast),
      .entry      (entry)
   );

   mse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (entry),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   mse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/mse_checker.sv =====
// Port-level checker for the multiboot stream encryptor, bound to the top level.
module mse_checker import mse_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_host_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HOST |-> !rsp_tlast)
      else $error("host key marked as end of run");

   a_trail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TRAIL |-> rsp_tlast)
      else $error("trailer not marked as end of run");

   a_host_then_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_HOST |=>
         rsp_tvalid && rsp_tuser == KIND_PLAIN && rsp_tlast)
      else $error("host key not followed by the first plain word");

endmodule

bind multiboot_stream_encryptor mse_checker u_mse_checker (.*);

// ===== test/multiboot_stream_encryptor_tb.sv =====
// Self-checking testbench for the multiboot stream encryptor: random uploads, idles, checks.
module multiboot_stream_encryptor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mse_pkg::*;

   // Cycles with no request, result or register write before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Output pipe is a four-deep queue plus an output register; allow that much and more.
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_WORDS = 200;
   localparam int RANDOM_PHASES = 8;
   localparam int PRINT_CAP = 40;

   typedef struct {
      logic [31:0] word;
      logic        first;
      logic        last;
   } image_word_type;

   typedef struct {
      logic [31:0] word;
      logic [1:0]  kind;
      logic        closes;
   } wire_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // plain_word
   logic        req_tuser = 1'b0;  // first_word
   logic        req_tlast = 1'b0;  // last_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // wire_word
   logic [1:0]  rsp_tuser;         // word_kind
   logic        rsp_tlast;         // end_of_run
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_SEED;
   logic [31:0] csr_data = '0;

   // Predictor copy of the registers and the cipher state.
   logic [31:0] link_seed;
   logic [17:0] image_length;
   logic [31:0] cipher_key;
   logic [15:0] image_crc;
   logic [17:0] image_offset;

   image_word_type  image_q[$];     // requests waiting for the driver
   wire_result_type wire_due_q[$];  // link words predicted but not yet seen

   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned results_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned uploads = 0;
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;

   logic req_taken = 1'b0;
   logic req_steady = 1'b0;
   logic rsp_steady = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;

   multiboot_stream_encryptor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // Reflected CRC-16 over one word, least significant bit first.
   function automatic logic [15:0] crc16_word(input logic [15:0] c, input logic [31:0] d);
      logic fb;
      for (int k = 0; k < 32; k++) begin
         fb = c[0] ^ d[k];
         c = c >> 1;
         if (fb) c = c ^ CRC_TAPS;
      end
      return c;
   endfunction

   // Host key word that announces the image size to the receiver.
   function automatic logic [31:0] link_key(input logic [17:0] len);
      logic [31:0] size;
      logic [31:0] a;
      logic [31:0] sum;
      logic [31:0] b;
      size = ({14'd0, len} - 32'h0000_0200) >> 3;  // wraps for short images
      a = 32'h0038_0000;
      a[6:0] = size[6:0];
      a[14:8] = size[13:7];
      a[16] = size[14];
      sum = (a >> 8) + (a >> 16) + a;
      b = {sum[7:0], 24'd0} | a | 32'h8080_8080;
      return b[9] ? (b ^ SEDO_WORD) : (b ^ KAWA_WORD);
   endfunction

   function automatic logic [31:0] offset_mask(input logic [17:0] off);
      return 32'd0 - ({14'd0, off} + OFFSET_BIAS);
   endfunction

   function automatic void expect_word(input logic [31:0] w, input logic [1:0] k,
                                       input logic closes);
      wire_result_type r;
      r.word = w;
      r.kind = k;
      r.closes = closes;
      wire_due_q.push_back(r);
   endfunction

   // Advance the cipher by one accepted request and queue the link words it yields.
   function automatic void encrypt_request(input logic [31:0] word, input logic first,
                                           input logic last);
      logic        trail;
      logic [31:0] enc;
      trail = last;
      if (first) begin
         expect_word(link_key(image_length), KIND_HOST, 1'b0);
         image_offset = '0;
         image_crc = CRC_INIT;
         cipher_key = link_seed ^ SEDO_WORD;
         trail = 1'b0;  // an upload that starts here never closes in the same request
      end
      if (image_offset < HEADER_END) begin
         expect_word(word, KIND_PLAIN, !trail);
      end else begin
         image_crc = crc16_word(image_crc, word);
         cipher_key = cipher_key * KAWA_WORD + 32'd1;
         enc = word ^ cipher_key ^ offset_mask(image_offset) ^ BY_WORD;
         expect_word(enc, KIND_BODY, !trail);
      end
      image_offset = image_offset + 18'd4;  // wraps at 2^18 by width
      if (trail) begin
         cipher_key = cipher_key * KAWA_WORD + 32'd1;
         enc = {image_length[15:0], image_crc} ^ cipher_key ^ offset_mask(image_offset)
               ^ BY_WORD;
         expect_word(enc, KIND_TRAIL, 1'b1);
      end
   endfunction

   function automatic void note_mismatch(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      errors++;
      if (errors <= PRINT_CAP)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_word(input logic [31:0] w, input logic first,
                                      input logic last);
      image_word_type it;
      it.word = w;
      it.first = first;
      it.last = last;
      image_q.push_back(it);
      words_queued++;
   endfunction

   // Queue one upload: mostly whole images long enough to reach the body, some short
   // ones, some cut off before their last word, and a little flag noise.
   function automatic int queue_upload();
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (roll < 87) begin
         if (roll < 65) n = $urandom_range(49, 110);
         else if (roll < 77) n = $urandom_range(2, 48);
         else n = $urandom_range(1, 60);
         queue_word(pick_word(), 1'b1, 1'b0);
         for (int k = 1; k < n - 1; k++) queue_word(pick_word(), 1'b0, 1'b0);
         if (n > 1) queue_word(pick_word(), 1'b0, roll < 77);
         uploads++;
      end else begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++)
            queue_word(pick_word(), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
      end
      return n;
   endfunction

   task automatic write_csr(input logic idx, input logic [31:0] val);
      int unsigned target;
      target = csr_writes + 1;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (csr_writes != target);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued request is in and every predicted word has come out.
   task automatic settle();
      while (words_taken != words_queued || wire_due_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- request driver

   always @(negedge clock) begin : drive_requests
      image_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the request until the block takes it
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (image_q.size() > 0) begin
         nxt = image_q.pop_front();
         req_tdata <= nxt.word;
         req_tuser <= nxt.first;
         req_tlast <= nxt.last;
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 49) == 0) req_steady = !req_steady;
         req_gap = req_steady ? 0 : draw_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- result back-pressure

   always @(negedge clock) begin : drive_ready
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 63) == 0) rsp_steady = !rsp_steady;
         if (!rsp_steady && $urandom_range(0, 3) == 0) rsp_hold = draw_gap();
      end
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin : watch_link
      wire_result_type want;
      logic busy;
      req_taken <= req_tvalid && req_tready;
      busy = 1'b0;
      if (!reset) begin
         // register writes land in the predictor at the same edge as in the block
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SEED) link_seed = csr_data;
            else image_length = csr_data[17:0];
            csr_writes++;
            busy = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            encrypt_request(req_tdata, req_tuser, req_tlast);
            words_taken++;
            busy = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            if (wire_due_q.size() == 0) begin
               note_mismatch("unexpected result, wire_word", 32'h0, rsp_tdata);
            end else begin
               want = wire_due_q.pop_front();
               results_checked++;
               if (rsp_tdata !== want.word) note_mismatch("wire_word", want.word, rsp_tdata);
               if (rsp_tuser !== want.kind)
                  note_mismatch("word_kind", {30'd0, want.kind}, {30'd0, rsp_tuser});
               if (rsp_tlast !== want.closes)
                  note_mismatch("end_of_run", {31'd0, want.closes}, {31'd0, rsp_tlast});
            end
         end
      end
      // drop the run if nothing moves for too long
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no traffic for %0d cycles, %0d words still due",
                  $realtime, WATCHDOG_LIMIT, wire_due_q.size());
         $display("multiboot_stream_encryptor test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin : run_test
      int added;
      int unsigned new_length;
      link_seed = '0;
      image_length = 18'd192;
      cipher_key = '0;
      image_crc = CRC_INIT;
      image_offset = '0;

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed, reset settings (short image length): words before any upload run on
      // the reset state, a last word with no upload, first and last together, and a
      // last word still inside the plain header.
      @(posedge clock);
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b1);
      queue_word(32'h0000_0001, 1'b0, 1'b0);
      queue_word(32'h8000_0000, 1'b0, 1'b1);
      settle();

      // Largest seed and length: length bits above 15 must not reach the trailer.
      write_csr(CSR_SEED, 32'hFFFF_FFFF);
      write_csr(CSR_LENGTH, 32'h0003_FFFF);
      @(posedge clock);
      queue_word(32'hA5A5_5A5A, 1'b1, 1'b0);
      queue_word(32'h5A5A_A5A5, 1'b0, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0, 1'b1);
      queue_word(32'h0000_0000, 1'b1, 1'b1);
      settle();

      // Zero seed, length just below the wrap point of the size term.
      write_csr(CSR_SEED, 32'h0000_0000);
      write_csr(CSR_LENGTH, 32'h0000_01FF);
      @(posedge clock);
      queue_word(32'h1234_5678, 1'b1, 1'b0);
      queue_word(32'h8765_4321, 1'b0, 1'b1);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      settle();

      // Random phases, each under its own seed and length, extremes first.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: new_length = 192;
            1: new_length = 262143;
            2: new_length = 511;
            3: new_length = 512;
            default: new_length = $urandom_range(192, 262143);
         endcase
         if (phase[0]) begin
            write_csr(CSR_LENGTH, new_length);
            write_csr(CSR_SEED, phase == 1 ? 32'hFFFF_FFFF : $urandom());
         end else begin
            write_csr(CSR_SEED, phase == 0 ? 32'h0000_0000 : $urandom());
            write_csr(CSR_LENGTH, new_length);
         end
         @(posedge clock);
         added = 0;
         while (added < PHASE_WORDS) added += queue_upload();
         settle();
      end

      $display("Sent %0d requests in %0d uploads under %0d register writes;",
               words_taken, uploads, csr_writes);
      $display("checked %0d link words across short, long and partial uploads, %0d errors.",
               results_checked, errors);
      if (errors == 0)
         $display("multiboot_stream_encryptor test passed");
      else
         $display("multiboot_stream_encryptor test failed");
      $finish;
   end

endmodule
